// ===== src/trps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-rail power sequencer package
// Shared types, codes and constants of the two-rail power sequencer.
// ----------------------------------------------------------------------------
package trps_pkg;

  localparam int TimeW  = 32;
  localparam int CfgW   = 32;
  localparam int NumCfg = 3;
  localparam int CfgIdxW = $clog2(NumCfg);

  typedef enum logic [2:0] {
    ST_OFF          = 3'd0,
    ST_PRI_STARTING = 3'd1,
    ST_PRI_ON       = 3'd2,
    ST_BRK_STARTING = 3'd3,
    ST_OPERATIONAL  = 3'd4,
    ST_STOPPING     = 3'd5,
    ST_FAULT        = 3'd6
  } state_e;

  typedef enum logic [1:0] {
    REQ_OFF     = 2'd0,
    REQ_PRIMARY = 2'd1,
    REQ_SYSTEM  = 2'd2
  } request_e;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET_REQ = 2'd1,
    OP_CLEAR   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CODE_LINK     = 2'd0,
    CODE_WRITE    = 2'd1,
    CODE_TIMEOUT  = 2'd2,
    CODE_MISMATCH = 2'd3
  } fault_code_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_PRIMARY_TIMEOUT = 2'd0,
    CFG_BREAKER_TIMEOUT = 2'd1,
    CFG_SETTLE_TIME     = 2'd2
  } cfg_idx_e;

  localparam logic [CfgW-1:0] PrimaryTimeoutRst = CfgW'(1000);
  localparam logic [CfgW-1:0] BreakerTimeoutRst = CfgW'(1000);
  localparam logic [CfgW-1:0] SettleTimeRst     = CfgW'(100);

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [1:0]  request_value;
    logic        link_ok;
    logic        ext_fault;
    logic        primary_power_good;
    logic        breaker_feedback_valid;
    logic        breaker_is_on;
    logic        output_write_ok;
  } req_item_t;

  typedef struct packed {
    logic [2:0] power_state;
    logic       primary_drive;
    logic       breaker_drive;
    logic       fault_event;
    logic [1:0] fault_code;
    logic       clear_accepted;
  } rsp_item_t;

  typedef struct packed {
    logic [CfgW-1:0] primary_start_timeout;
    logic [CfgW-1:0] breaker_start_timeout;
    logic [CfgW-1:0] shutdown_settle_time;
  } cfg_t;

  typedef struct packed {
    state_e           state;
    request_e         request;
    logic [TimeW-1:0] entered_time;
    logic             primary_cmd;
    logic             breaker_cmd;
  } seq_state_t;

endpackage

// ===== src/trps_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-rail power sequencer channels
// Valid/ready channels that carry requests into the block and results out.
// ----------------------------------------------------------------------------
interface trps_req_if;
  logic                  valid;
  logic                  ready;
  trps_pkg::req_item_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface trps_rsp_if;
  logic                  valid;
  logic                  ready;
  trps_pkg::rsp_item_t   payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== src/trps_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-rail power sequencer configuration registers
// Holds the start timeouts and the shutdown settle time.
// ----------------------------------------------------------------------------
module trps_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [trps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [trps_pkg::CfgW-1:0]       cfg_wdata_i,
  output trps_pkg::cfg_t                  cfg_o
);

  trps_pkg::cfg_t cfg_d, cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        trps_pkg::CFG_PRIMARY_TIMEOUT: cfg_d.primary_start_timeout = cfg_wdata_i;
        trps_pkg::CFG_BREAKER_TIMEOUT: cfg_d.breaker_start_timeout = cfg_wdata_i;
        trps_pkg::CFG_SETTLE_TIME:     cfg_d.shutdown_settle_time  = cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.primary_start_timeout <= trps_pkg::PrimaryTimeoutRst;
      cfg_q.breaker_start_timeout <= trps_pkg::BreakerTimeoutRst;
      cfg_q.shutdown_settle_time  <= trps_pkg::SettleTimeRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== src/trps_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-rail power sequencer step logic
// Computes the next sequencer state and the result for one request.
// ----------------------------------------------------------------------------
module trps_step (
  input  trps_pkg::req_item_t   item_i,
  input  trps_pkg::seq_state_t  cur_i,
  input  trps_pkg::cfg_t        cfg_i,
  output trps_pkg::seq_state_t  nxt_o,
  output trps_pkg::rsp_item_t   rsp_o
);

  logic [trps_pkg::TimeW-1:0] now;
  logic [trps_pkg::TimeW-1:0] elapsed;
  logic                       allowed;
  logic                       go_fault;
  trps_pkg::fault_code_e      code;
  logic                       cleared;
  trps_pkg::seq_state_t       nxt;

  assign now     = item_i.now_ms[trps_pkg::TimeW-1:0];
  assign elapsed = now - cur_i.entered_time;
  assign allowed = item_i.link_ok && !item_i.ext_fault;

  always_comb begin
    nxt      = cur_i;
    go_fault = 1'b0;
    code     = trps_pkg::CODE_LINK;
    cleared  = 1'b0;
    unique case (trps_pkg::opcode_e'(item_i.opcode))
      trps_pkg::OP_TICK: begin
        if (!allowed && cur_i.state != trps_pkg::ST_OFF &&
            cur_i.state != trps_pkg::ST_FAULT) begin
          go_fault = 1'b1;
          code     = trps_pkg::CODE_LINK;
        end else begin
          unique case (cur_i.state)
            trps_pkg::ST_OFF: begin
              if (cur_i.request != trps_pkg::REQ_OFF && allowed) begin
                if (!item_i.output_write_ok) begin
                  go_fault = 1'b1;
                  code     = trps_pkg::CODE_WRITE;
                end else begin
                  nxt.primary_cmd  = 1'b1;
                  nxt.state        = trps_pkg::ST_PRI_STARTING;
                  nxt.entered_time = now;
                end
              end
            end
            trps_pkg::ST_PRI_STARTING: begin
              if (cur_i.request == trps_pkg::REQ_OFF) begin
                nxt.state        = trps_pkg::ST_STOPPING;
                nxt.entered_time = now;
              end else if (item_i.primary_power_good) begin
                nxt.state        = trps_pkg::ST_PRI_ON;
                nxt.entered_time = now;
              end else if (elapsed >= cfg_i.primary_start_timeout) begin
                go_fault = 1'b1;
                code     = trps_pkg::CODE_TIMEOUT;
              end
            end
            trps_pkg::ST_PRI_ON: begin
              if (cur_i.request == trps_pkg::REQ_OFF) begin
                nxt.state        = trps_pkg::ST_STOPPING;
                nxt.entered_time = now;
              end else if (cur_i.request == trps_pkg::REQ_SYSTEM) begin
                if (!item_i.output_write_ok) begin
                  go_fault = 1'b1;
                  code     = trps_pkg::CODE_WRITE;
                end else begin
                  nxt.breaker_cmd  = 1'b1;
                  nxt.state        = trps_pkg::ST_BRK_STARTING;
                  nxt.entered_time = now;
                end
              end
            end
            trps_pkg::ST_BRK_STARTING: begin
              if (cur_i.request != trps_pkg::REQ_SYSTEM) begin
                nxt.breaker_cmd  = 1'b0;
                nxt.state        = trps_pkg::ST_PRI_ON;
                nxt.entered_time = now;
              end else if (item_i.breaker_feedback_valid && item_i.breaker_is_on) begin
                nxt.state        = trps_pkg::ST_OPERATIONAL;
                nxt.entered_time = now;
              end else if (elapsed >= cfg_i.breaker_start_timeout) begin
                go_fault = 1'b1;
                code     = trps_pkg::CODE_TIMEOUT;
              end
            end
            trps_pkg::ST_OPERATIONAL: begin
              if (cur_i.request != trps_pkg::REQ_SYSTEM) begin
                nxt.breaker_cmd  = 1'b0;
                nxt.state        = (cur_i.request == trps_pkg::REQ_OFF) ?
                                   trps_pkg::ST_STOPPING : trps_pkg::ST_PRI_ON;
                nxt.entered_time = now;
              end else if (!item_i.breaker_feedback_valid || !item_i.breaker_is_on) begin
                go_fault = 1'b1;
                code     = trps_pkg::CODE_MISMATCH;
              end
            end
            trps_pkg::ST_STOPPING: begin
              if (cur_i.breaker_cmd) begin
                nxt.breaker_cmd  = 1'b0;
                nxt.entered_time = now;
              end else if (elapsed >= cfg_i.shutdown_settle_time) begin
                if (!item_i.output_write_ok) begin
                  go_fault = 1'b1;
                  code     = trps_pkg::CODE_WRITE;
                end else begin
                  nxt.primary_cmd  = 1'b0;
                  nxt.state        = trps_pkg::ST_OFF;
                  nxt.entered_time = now;
                end
              end
            end
            default: ;
          endcase
        end
      end
      trps_pkg::OP_SET_REQ: begin
        if (item_i.request_value == 2'd3) begin
          nxt.request = trps_pkg::REQ_PRIMARY;
        end else begin
          nxt.request = trps_pkg::request_e'(item_i.request_value);
        end
      end
      trps_pkg::OP_CLEAR: begin
        if (cur_i.state == trps_pkg::ST_FAULT && allowed) begin
          nxt.request      = trps_pkg::REQ_OFF;
          nxt.state        = trps_pkg::ST_OFF;
          nxt.entered_time = now;
          cleared          = 1'b1;
        end
      end
      default: ;
    endcase

    if (go_fault) begin
      nxt.primary_cmd  = 1'b0;
      nxt.breaker_cmd  = 1'b0;
      nxt.request      = trps_pkg::REQ_OFF;
      nxt.state        = trps_pkg::ST_FAULT;
      nxt.entered_time = now;
    end
  end

  assign nxt_o = nxt;

  assign rsp_o.power_state    = nxt.state;
  assign rsp_o.primary_drive  = nxt.primary_cmd;
  assign rsp_o.breaker_drive  = nxt.breaker_cmd;
  assign rsp_o.fault_event    = go_fault;
  assign rsp_o.fault_code     = go_fault ? code : trps_pkg::CODE_LINK;
  assign rsp_o.clear_accepted = cleared;

endmodule

// ===== src/two_rail_power_sequencer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-rail power sequencer core
// Brings a primary rail and a downstream breaker up and down in order.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while the result side is ready
// and returns exactly one result for each. A request is first captured in an
// input register; the sequencer state is then updated while the result is
// written to an output register, and that one state update sets the rate.
// Backpressure on the result side stalls the input register, which still
// takes a new request in the cycle the waiting result leaves. Configuration
// writes take effect on the next cycle and must be made while no request is
// in flight.
module two_rail_power_sequencer_core (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [trps_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [trps_pkg::CfgW-1:0]       cfg_wdata_i,
  trps_req_if.sink                        req_i,
  trps_rsp_if.source                      rsp_o
);

  trps_pkg::cfg_t        cfg;
  trps_pkg::req_item_t   in_q;
  logic                  in_valid_q;
  trps_pkg::rsp_item_t   out_d, out_q;
  logic                  out_valid_q;
  trps_pkg::seq_state_t  state_d, state_q;
  logic                  advance;
  logic                  in_ready;

  trps_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  trps_step u_step (
    .item_i (in_q),
    .cur_i  (state_q),
    .cfg_i  (cfg),
    .nxt_o  (state_d),
    .rsp_o  (out_d)
  );

  assign advance  = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign in_ready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q            <= 1'b0;
      out_valid_q           <= 1'b0;
      state_q.state         <= trps_pkg::ST_OFF;
      state_q.request       <= trps_pkg::REQ_OFF;
      state_q.entered_time  <= '0;
      state_q.primary_cmd   <= 1'b0;
      state_q.breaker_cmd   <= 1'b0;
    end else begin
      if (in_ready) begin
        in_valid_q <= req_i.valid;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      in_q <= req_i.payload;
    end
    if (advance) begin
      out_q <= out_d;
    end
  end

  assign req_i.ready   = in_ready;
  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

endmodule
